// ----- sv/apsm_pkg.sv -----
package apsm_pkg;

  localparam int MAX_SOLIDS = 16;
  localparam int IDX_W      = (MAX_SOLIDS > 1) ? $clog2(MAX_SOLIDS) : 1;
  localparam int CNT_W      = IDX_W + 1;

  localparam int POS_W      = 16;
  localparam int SIZE_W     = 12;
  localparam int SLOT_W     = 4;
  localparam int STEP_W     = 11;
  localparam int REM_W      = 11;
  localparam int COUNT_W    = 5;
  localparam int EDGE_W     = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;

  localparam logic [1:0] CMD_LOAD_SOLID = 2'd0;
  localparam logic [1:0] CMD_SET_POS    = 2'd1;
  localparam logic [1:0] CMD_MOVE_X     = 2'd2;
  localparam logic [1:0] CMD_MOVE_Y     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTOR_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTOR_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID_COUNT  = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0]       h;
    logic [SIZE_W-1:0]       w;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } solid_t;

  typedef struct packed {
    logic                    stopped_early;
    logic                    hit_y;
    logic                    hit_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic take_step;
    logic scan_start;
    logic scan_run;
    logic set_hit;
    logic set_early;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_move;
    logic rem_zero;
    logic at_limit;
    logic count_zero;
    logic cmp_valid;
    logic cmp_last;
    logic overlap;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/apsm_ctrl.sv -----
module apsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  apsm_pkg::dp_stat_t stat,
  output apsm_pkg::dp_cmd_t  ctl
);
  import apsm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = stat.is_move ? ST_STEP : ST_DONE;
        end
      end
      ST_STEP: begin
        if (stat.rem_zero) begin
          state_next = ST_DONE;
        end else if (stat.at_limit) begin
          ctl.set_early = 1'b1;
          state_next    = ST_DONE;
        end else if (stat.count_zero) begin
          ctl.take_step = 1'b1;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads are issued one solid per cycle while the previous one is compared.
        if (stat.cmp_valid && stat.overlap) begin
          ctl.set_hit   = 1'b1;
          ctl.set_early = 1'b1;
          state_next    = ST_DONE;
        end else if (stat.cmp_valid && stat.cmp_last) begin
          ctl.take_step = 1'b1;
          state_next    = ST_STEP;
        end else begin
          ctl.scan_run = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/apsm_dp.sv -----
module apsm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [apsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apsm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          in_cmd,
  input  logic [apsm_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [apsm_pkg::POS_W-1:0]   in_coord_x,
  input  logic signed [apsm_pkg::POS_W-1:0]   in_coord_y,
  input  logic [apsm_pkg::SIZE_W-1:0]         in_rect_w,
  input  logic [apsm_pkg::SIZE_W-1:0]         in_rect_h,
  input  logic signed [apsm_pkg::STEP_W-1:0]  in_step_amount,
  input  apsm_pkg::dp_cmd_t                   ctl,
  output apsm_pkg::dp_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output apsm_pkg::result_t                   out_result
);
  import apsm_pkg::*;

  logic [SIZE_W-1:0]       actor_width;
  logic [SIZE_W-1:0]       actor_height;
  logic [COUNT_W-1:0]      solid_count;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    hit_x;
  logic                    hit_y;
  logic                    early;

  logic                    axis_x;
  logic                    dir_neg;
  logic [REM_W-1:0]        rem;

  solid_t                  mem [MAX_SOLIDS];
  solid_t                  rd_data;
  logic [IDX_W-1:0]        rd_idx;
  logic                    cmp_valid;
  logic                    cmp_last;

  logic signed [EDGE_W-1:0] tx;
  logic signed [EDGE_W-1:0] ty;
  logic signed [EDGE_W-1:0] tx_end;
  logic signed [EDGE_W-1:0] ty_end;

  logic [CNT_W-1:0]         n_used;
  logic signed [POS_W-1:0]  pos_cur;
  logic signed [EDGE_W-1:0] delta;
  logic signed [EDGE_W-1:0] tx_calc;
  logic signed [EDGE_W-1:0] ty_calc;
  logic signed [EDGE_W-1:0] sx;
  logic signed [EDGE_W-1:0] sy;
  logic signed [EDGE_W-1:0] sx_end;
  logic signed [EDGE_W-1:0] sy_end;
  logic [STEP_W:0]          amt_mag;

  assign n_used  = (int'(solid_count) > MAX_SOLIDS) ? CNT_W'(MAX_SOLIDS)
                                                    : CNT_W'(solid_count);
  assign pos_cur = axis_x ? pos_x : pos_y;
  assign delta   = dir_neg ? -EDGE_W'(1) : EDGE_W'(1);
  assign tx_calc = EDGE_W'(pos_x) + (axis_x ? delta : '0);
  assign ty_calc = EDGE_W'(pos_y) + (axis_x ? '0 : delta);

  assign sx     = EDGE_W'(rd_data.x);
  assign sy     = EDGE_W'(rd_data.y);
  assign sx_end = sx + $signed({{(EDGE_W-SIZE_W){1'b0}}, rd_data.w});
  assign sy_end = sy + $signed({{(EDGE_W-SIZE_W){1'b0}}, rd_data.h});

  // The magnitude of the most negative amount still fits the unsigned count.
  assign amt_mag = in_step_amount[STEP_W-1] ? -{in_step_amount[STEP_W-1], in_step_amount}
                                            : {in_step_amount[STEP_W-1], in_step_amount};

  always_comb begin
    stat            = '0;
    stat.is_move    = (in_cmd == CMD_MOVE_X) || (in_cmd == CMD_MOVE_Y);
    stat.rem_zero   = (rem == '0);
    stat.at_limit   = dir_neg ? (pos_cur == POS_MIN) : (pos_cur == POS_MAX);
    stat.count_zero = (n_used == '0);
    stat.cmp_valid  = cmp_valid;
    stat.cmp_last   = cmp_last;
    stat.overlap    = (sx < tx_end) && (sx_end > tx) && (sy < ty_end) && (sy_end > ty);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      actor_width  <= SIZE_W'(8);
      actor_height <= SIZE_W'(8);
      solid_count  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTOR_WIDTH:  actor_width  <= cfg_data;
        CFG_ACTOR_HEIGHT: actor_height <= cfg_data;
        CFG_SOLID_COUNT:  solid_count  <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item && (in_cmd == CMD_LOAD_SOLID) && (int'(in_slot) < MAX_SOLIDS)) begin
      mem[IDX_W'(in_slot)] <= '{h: in_rect_h, w: in_rect_w, y: in_coord_y, x: in_coord_x};
    end
    if (ctl.scan_run) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      hit_x     <= 1'b0;
      hit_y     <= 1'b0;
      early     <= 1'b0;
      rem       <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_item) begin
        early <= 1'b0;
        rem   <= '0;
        case (in_cmd)
          CMD_SET_POS: begin
            pos_x <= in_coord_x;
            pos_y <= in_coord_y;
          end
          CMD_MOVE_X, CMD_MOVE_Y: begin
            rem <= amt_mag[REM_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (ctl.take_step) begin
        rem <= rem - REM_W'(1);
        if (axis_x) begin
          pos_x <= tx_calc[POS_W-1:0];
        end else begin
          pos_y <= ty_calc[POS_W-1:0];
        end
      end
      if (ctl.scan_start) begin
        cmp_valid <= 1'b0;
      end else if (ctl.scan_run) begin
        cmp_valid <= 1'b1;
      end
      if (ctl.set_hit) begin
        if (axis_x) begin
          hit_x <= 1'b1;
        end else begin
          hit_y <= 1'b1;
        end
      end
      if (ctl.set_early) begin
        early <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      axis_x  <= (in_cmd == CMD_MOVE_X);
      dir_neg <= in_step_amount[STEP_W-1];
    end
    if (ctl.scan_start) begin
      tx     <= tx_calc;
      ty     <= ty_calc;
      tx_end <= tx_calc + $signed({{(EDGE_W-SIZE_W){1'b0}}, actor_width});
      ty_end <= ty_calc + $signed({{(EDGE_W-SIZE_W){1'b0}}, actor_height});
      rd_idx <= '0;
    end else if (ctl.scan_run) begin
      rd_idx   <= rd_idx + IDX_W'(1);
      cmp_last <= ({1'b0, rd_idx} == (n_used - CNT_W'(1)));
    end
    if (ctl.out_load) begin
      out_result <= '{stopped_early: early, hit_y: hit_y, hit_x: hit_x,
                      pos_y: pos_y, pos_x: pos_x};
    end
  end

endmodule

// ----- sv/aabb_pixel_step_mover.sv -----
// Moves one actor rectangle against a table of up to 16 solid rectangles. Each
// input item gives one result item with the actor position and the sticky hit
// flags after it. A move is made one unit step at a time; each step checks the
// coordinate limit and, when solids are in use, reads the solids in use through
// a registered read and compares them: the solid table has one read port and
// one solid is compared per cycle. A move that is blocked ends at the step that
// would overlap. The next item is taken while the previous result still waits
// at the output.
module aabb_pixel_step_mover (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // slot[3:0], coord_x[19:4], coord_y[35:20], rect_w[47:36], rect_h[59:48],
  // step_amount[70:60], zero[71]
  input  logic [apsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pos_x[15:0], pos_y[31:16], hit_x[32], hit_y[33], stopped_early[34], zero[39:35]
  output logic [apsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import apsm_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;
  result_t  result;

  assign cfg_ready = 1'b1;

  apsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  apsm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (s_axis_tuser),
    .in_slot        (s_axis_tdata[3:0]),
    .in_coord_x     ($signed(s_axis_tdata[19:4])),
    .in_coord_y     ($signed(s_axis_tdata[35:20])),
    .in_rect_w      (s_axis_tdata[47:36]),
    .in_rect_h      (s_axis_tdata[59:48]),
    .in_step_amount ($signed(s_axis_tdata[70:60])),
    .ctl            (ctl),
    .stat           (stat),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .out_result     (result)
  );

  assign m_axis_tdata = {(OUT_DATA_W - $bits(result_t))'(0), result};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a waiting result");

  a_step_or_block: assert property (@(posedge clk) disable iff (rst)
    !(ctl.take_step && ctl.set_hit))
    else $error("step taken and blocked in the same cycle");

  a_hit_blocks_step: assert property (@(posedge clk) disable iff (rst)
    ctl.set_hit |=> !ctl.take_step && !ctl.scan_run)
    else $error("move continued after a block");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import apsm_pkg::*;

  // Writes to this index must leave every register unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // Field order of s_axis_tdata, highest bits first.
  typedef struct packed {
    logic                    pad;
    logic signed [STEP_W-1:0] step_amount;
    logic [SIZE_W-1:0]       rect_h;
    logic [SIZE_W-1:0]       rect_w;
    logic signed [POS_W-1:0] coord_y;
    logic signed [POS_W-1:0] coord_x;
    logic [SLOT_W-1:0]       slot;
  } mover_item_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted state of the mover.
  int     cur_x;
  int     cur_y;
  logic   hit_x_seen;
  logic   hit_y_seen;
  solid_t solids [MAX_SOLIDS];
  int     act_w;
  int     act_h;
  int     live_solids;

  result_t expected_positions [$];
  int      mismatch_count;
  int      results_seen;
  logic    tx_no_gaps;
  logic    rx_no_stalls;
  logic    item_valid_on;
  longint  cycle_count;
  longint  cycle_budget;

  aabb_pixel_step_mover dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("aabb_pixel_step_mover test failed");
      $finish;
    end
  end

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Strict overlap of the actor placed at (ax, ay) with any solid in use.
  function automatic logic solid_hit_at(input int ax, input int ay);
    int used;
    int i;
    int sx;
    int sy;
    used = (live_solids > MAX_SOLIDS) ? MAX_SOLIDS : live_solids;
    for (i = 0; i < used; i++) begin
      sx = solids[i].x;
      sy = solids[i].y;
      if (sx < ax + act_w && sx + int'(solids[i].w) > ax &&
          sy < ay + act_h && sy + int'(solids[i].h) > ay)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Steps the actor one unit at a time; returns 1 when the move ends early.
  function automatic logic walk_actor(input int amount, input logic along_x);
    int dir;
    int next;
    if (amount == 0)
      return 1'b0;
    dir = (amount > 0) ? 1 : -1;
    while (amount != 0) begin
      next = (along_x ? cur_x : cur_y) + dir;
      if (next < POS_MIN || next > POS_MAX)
        return 1'b1;
      if (solid_hit_at(along_x ? next : cur_x, along_x ? cur_y : next)) begin
        if (along_x)
          hit_x_seen = 1'b1;
        else
          hit_y_seen = 1'b1;
        return 1'b1;
      end
      if (along_x)
        cur_x = next;
      else
        cur_y = next;
      amount -= dir;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_actor(input logic [1:0] cmd, input mover_item_t item);
    result_t res;
    res.stopped_early = 1'b0;
    case (cmd)
      CMD_LOAD_SOLID: begin
        solids[item.slot] = '{x: item.coord_x, y: item.coord_y,
                              w: item.rect_w, h: item.rect_h};
      end
      CMD_SET_POS: begin
        cur_x = item.coord_x;
        cur_y = item.coord_y;
      end
      CMD_MOVE_X: res.stopped_early = walk_actor(item.step_amount, 1'b1);
      CMD_MOVE_Y: res.stopped_early = walk_actor(item.step_amount, 1'b0);
    endcase
    res.pos_x = 16'(cur_x);
    res.pos_y = 16'(cur_y);
    res.hit_x = hit_x_seen;
    res.hit_y = hit_y_seen;
    return res;
  endfunction

  task automatic flag_mismatch(input string text);
    mismatch_count++;
    $display("[%0t] %s", $time, text);
  endtask

  task automatic send_item(input logic [1:0] cmd, input mover_item_t item);
    int gap;
    int amt;
    int used;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      if (item_valid_on) begin
        s_axis_tvalid <= 1'b0;
        item_valid_on = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= cmd;
    item_valid_on = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    // Allow each item its slowest case: every step scans every solid in use.
    amt = (cmd == CMD_MOVE_X || cmd == CMD_MOVE_Y) ? int'(item.step_amount) : 0;
    if (amt < 0)
      amt = -amt;
    used = (live_solids > MAX_SOLIDS) ? MAX_SOLIDS : live_solids;
    cycle_budget += 4 * (3 + amt * (used + 2) + 45);
    expected_positions.push_back(advance_actor(cmd, item));
  endtask

  // Unused fields carry random values; the block must ignore them.
  function automatic mover_item_t noise_item();
    mover_item_t item;
    item = mover_item_t'({$urandom, $urandom, $urandom});
    item.pad = 1'b0;
    return item;
  endfunction

  task automatic send_load(input int slot, input int x, input int y, input int w, input int h);
    mover_item_t item;
    item = noise_item();
    item.slot    = 4'(slot);
    item.coord_x = 16'(x);
    item.coord_y = 16'(y);
    item.rect_w  = 12'(w);
    item.rect_h  = 12'(h);
    send_item(CMD_LOAD_SOLID, item);
  endtask

  task automatic send_place(input int x, input int y);
    mover_item_t item;
    item = noise_item();
    item.coord_x = 16'(x);
    item.coord_y = 16'(y);
    send_item(CMD_SET_POS, item);
  endtask

  task automatic send_move(input logic [1:0] cmd, input int amount);
    mover_item_t item;
    item = noise_item();
    item.step_amount = 11'(amount);
    send_item(cmd, item);
  endtask

  task automatic wait_for_results();
    if (item_valid_on) begin
      s_axis_tvalid <= 1'b0;
      item_valid_on = 1'b0;
    end
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cycle_budget += 100;
    case (idx)
      CFG_ACTOR_WIDTH:  act_w = data;
      CFG_ACTOR_HEIGHT: act_h = data;
      CFG_SOLID_COUNT:  live_solids = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic regs_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input int w, input int h, input int n);
    write_reg(CFG_ACTOR_WIDTH, w);
    write_reg(CFG_ACTOR_HEIGHT, h);
    write_reg(CFG_SOLID_COUNT, n);
    regs_done();
  endtask

  task automatic test_after_reset();
    send_move(CMD_MOVE_X, 0);
    send_move(CMD_MOVE_Y, 0);
  endtask

  // No solids are in use yet, so only the coordinate range stops these moves.
  task automatic test_coord_limits();
    send_place(-32768, 32767);
    send_move(CMD_MOVE_Y, 3);
    send_move(CMD_MOVE_X, -1);
    send_place(32767, -32768);
    send_move(CMD_MOVE_X, 1023);
    send_move(CMD_MOVE_Y, -1024);
  endtask

  // The actor still has its reset size of 8 by 8 here.
  task automatic test_default_size();
    send_load(0, 20, -2, 4, 4);
    wait_for_results();
    write_reg(CFG_SOLID_COUNT, 1);
    regs_done();
    send_place(0, 0);
    send_move(CMD_MOVE_X, 30);
    send_move(CMD_MOVE_X, -1024);
    send_move(CMD_MOVE_X, 1023);
  endtask

  // A zero sized actor overlaps only a solid that strictly surrounds its corner; a zero
  // sized solid still blocks an actor that would strictly contain it.
  task automatic test_zero_sizes();
    send_load(1, 100, 100, 0, 0);
    wait_for_results();
    program_regs(0, 0, 2);
    send_place(95, 100);
    send_move(CMD_MOVE_X, 10);
    wait_for_results();
    program_regs(8, 8, 2);
    send_place(90, 96);
    send_move(CMD_MOVE_X, 10);
    send_place(99, 90);
    send_move(CMD_MOVE_Y, 10);
  endtask

  task automatic test_wide_actor();
    send_load(15, 32767, 32767, 4095, 4095);
    send_load(2, -32768, -32768, 4095, 4095);
    wait_for_results();
    write_reg(CFG_UNUSED_INDEX, 4095);
    program_regs(4095, 4095, 3);
    send_place(-28000, -32768);
    send_move(CMD_MOVE_X, -1024);
    send_place(0, 0);
    send_move(CMD_MOVE_Y, -1);
  endtask

  // Solids and actor mostly share a small area so that moves collide often.
  task automatic test_random_world();
    int phase;
    int k;
    int r;
    int w;
    int h;
    int n;
    for (k = 0; k < MAX_SOLIDS; k++)
      send_load(k, rand_span(-200, 200), rand_span(-200, 200),
                rand_span(0, 40), rand_span(0, 40));
    for (phase = 0; phase < 12; phase++) begin
      wait_for_results();
      case (phase)
        0: begin w = 4095; h = 4095; n = 16; end
        1: begin w = 0;    h = 0;    n = 16; end
        2: begin w = 1;    h = 1;    n = 31; end
        3: begin w = 4095; h = 0;    n = 0;  end
        4: begin w = 0;    h = 4095; n = 8;  end
        default: begin
          w = rand_span(0, 48);
          h = rand_span(0, 48);
          n = rand_span(0, 16);
        end
      endcase
      program_regs(w, h, n);
      tx_no_gaps   = (phase % 4 == 1) || (phase % 4 == 2);
      rx_no_stalls = (phase % 4 == 1) || (phase % 4 == 3);
      for (k = 0; k < 157; k++) begin
        r = $urandom_range(0, 99);
        if (r < 1)
          send_load($urandom_range(0, 15), rand_span(-32768, 32767),
                    rand_span(-32768, 32767), rand_span(0, 4095), rand_span(0, 4095));
        else if (r < 12)
          send_load($urandom_range(0, 15), rand_span(-200, 200), rand_span(-200, 200),
                    rand_span(0, 40), rand_span(0, 40));
        else if (r < 16)
          send_place($urandom_range(0, 1) ? 32767 - rand_span(0, 15) : -32768 + rand_span(0, 15),
                     $urandom_range(0, 1) ? 32767 - rand_span(0, 15) : -32768 + rand_span(0, 15));
        else if (r < 18)
          send_place(rand_span(-32768, 32767), rand_span(-32768, 32767));
        else if (r < 26)
          send_place(rand_span(-200, 200), rand_span(-200, 200));
        else begin
          r = $urandom_range(0, 99);
          send_move($urandom_range(0, 1) ? CMD_MOVE_X : CMD_MOVE_Y,
                    (r < 85) ? rand_span(-12, 12) :
                    (r < 98) ? rand_span(-64, 64) : rand_span(-1024, 1023));
        end
      end
    end
  endtask

  initial begin : result_monitor
    int stall;
    result_t got;
    result_t want;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_no_stalls ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      results_seen++;
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (m_axis_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0)
        flag_mismatch($sformatf("result %0d: padding bits not zero", results_seen));
      if (expected_positions.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        want = expected_positions.pop_front();
        if (got.pos_x !== want.pos_x)
          flag_mismatch($sformatf("result %0d pos_x: got %0d, expected %0d",
                                  results_seen, got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
          flag_mismatch($sformatf("result %0d pos_y: got %0d, expected %0d",
                                  results_seen, got.pos_y, want.pos_y));
        if (got.hit_x !== want.hit_x)
          flag_mismatch($sformatf("result %0d hit_x: got %b, expected %b",
                                  results_seen, got.hit_x, want.hit_x));
        if (got.hit_y !== want.hit_y)
          flag_mismatch($sformatf("result %0d hit_y: got %b, expected %b",
                                  results_seen, got.hit_y, want.hit_y));
        if (got.stopped_early !== want.stopped_early)
          flag_mismatch($sformatf("result %0d stopped_early: got %b, expected %b",
                                  results_seen, got.stopped_early, want.stopped_early));
      end
    end
  end

  initial begin
    cur_x          = 0;
    cur_y          = 0;
    hit_x_seen     = 1'b0;
    hit_y_seen     = 1'b0;
    act_w          = 8;
    act_h          = 8;
    live_solids    = 0;
    mismatch_count = 0;
    results_seen   = 0;
    tx_no_gaps     = 1'b0;
    rx_no_stalls   = 1'b0;
    item_valid_on  = 1'b0;
    cycle_count    = 0;
    cycle_budget   = 50000;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD_SOLID;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_ACTOR_WIDTH;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_coord_limits();
    test_default_size();
    test_zero_sizes();
    test_wide_actor();
    test_random_world();

    wait_for_results();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0)
      $display("aabb_pixel_step_mover test passed");
    else
      $display("aabb_pixel_step_mover test failed");
    $finish;
  end

endmodule
